// ===== rtl/core/rm2q_pkg.sv =====
package rm2q_pkg;

    // Field widths of the matrix elements and the quaternion parts.
    localparam int ELEM_W   = 16;
    localparam int NUM_ELEM = 9;
    localparam int QW_W     = 15;
    localparam int QXYZ_W   = 16;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_DATA_W  = ELEM_W * NUM_ELEM;
    localparam int OUT_DATA_W = 64;

    // Largest magnitude a quaternion part may take.
    localparam logic [QW_W-1:0] MAG_MAX = 15'h7fff;

    // Lane order of the four root units.
    localparam int LANE_W = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_Z = 3;
    localparam int NUM_LANES = 4;

    // Sign flags of the vector part, carried alongside the roots.
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } neg_flags_t;

endpackage

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion, fixed point with FRAC_BITS fraction bits.
// Input channel s_axis_*: one item is a whole 3x3 matrix, nine signed elements
// packed in s_axis_tdata, row-major, element (0,0) in the lowest bits.
// Output channel m_axis_*: one item is the quaternion w, x, y, z.
// Each part is half the square root of one plus a signed sum of the diagonal,
// rounded down and saturated at 32767; x, y and z take the sign of the matching
// off-diagonal difference, positive when that difference is zero.
// RB = ceil((max(FRAC_BITS, 17) + 1 + FRAC_BITS) / 2) is the root width, 16 bits
// at FRAC_BITS = 14. The entry stage forms the diagonal sums, the
// restoring square root takes one stage per root bit (four lanes side by side),
// and the output stage saturates, applies the signs and registers the item.
// Throughput is one item per cycle while the receiver takes items.
// When the receiver stalls with a result waiting, the whole pipeline holds;
// items already inside are kept and the input drops s_axis_tready until the
// output register frees up, so nothing is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22
    input  logic [rm2q_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // quat_w (15), quat_x (16), quat_y (16), quat_z (16), one zero pad bit
    output logic [rm2q_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import rm2q_pkg::*;

    // Unsigned width of a clamped sum, its signed width, radicand and root widths.
    localparam int SW    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int SSW   = SW + 1;
    localparam int RW    = SW + FRAC_BITS;
    localparam int RB    = (RW + 1) / 2;
    localparam int RADW  = 2 * RB;
    localparam int REMW  = RB + 2;
    localparam int CURW  = RB + 4;
    localparam int MAGW  = RB - 1;
    localparam int EXTW  = (MAGW > QXYZ_W) ? MAGW : QXYZ_W;

    localparam logic signed [SSW-1:0] ONE = SSW'(1) <<< FRAC_BITS;

    // Pipeline advances whenever the output register can take a new item.
    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Stage registers: stage s holds the root after s iterations.
    logic                vld_reg  [0:RB];
    logic [RADW-1:0]     rad_reg  [0:RB][0:NUM_LANES-1];
    logic [REMW-1:0]     rem_reg  [0:RB][0:NUM_LANES-1];
    logic [RB-1:0]       root_reg [0:RB][0:NUM_LANES-1];
    neg_flags_t          neg_reg  [0:RB];

    // Unpack the matrix elements.
    logic signed [ELEM_W-1:0] rot [0:NUM_ELEM-1];
    for (genvar e = 0; e < NUM_ELEM; e++)
    begin : g_unpack
        assign rot[e] = s_axis_tdata[e*ELEM_W +: ELEM_W];
    end

    // Diagonal sums, sign-extended to the full sum width.
    logic signed [SSW-1:0] d0;
    logic signed [SSW-1:0] d1;
    logic signed [SSW-1:0] d2;
    logic signed [SSW-1:0] sum_next [0:NUM_LANES-1];
    logic [RADW-1:0]       rad_next [0:NUM_LANES-1];

    assign d0 = SSW'(rot[0]);
    assign d1 = SSW'(rot[4]);
    assign d2 = SSW'(rot[8]);

    assign sum_next[LANE_W] = ONE + d0 + d1 + d2;
    assign sum_next[LANE_X] = ONE + d0 - d1 - d2;
    assign sum_next[LANE_Y] = ONE - d0 + d1 - d2;
    assign sum_next[LANE_Z] = ONE - d0 - d1 + d2;

    // Clamp negative sums at zero and scale up by the fraction bits.
    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_rad
        logic [SW-1:0] clamped;
        assign clamped     = sum_next[l][SSW-1] ? '0 : sum_next[l][SW-1:0];
        assign rad_next[l] = RADW'({clamped, {FRAC_BITS{1'b0}}});
    end

    // Off-diagonal differences; only their signs are kept.
    logic signed [ELEM_W:0] dif_x;
    logic signed [ELEM_W:0] dif_y;
    logic signed [ELEM_W:0] dif_z;
    neg_flags_t             neg_next;

    assign dif_x = (ELEM_W+1)'(rot[7]) - (ELEM_W+1)'(rot[5]);
    assign dif_y = (ELEM_W+1)'(rot[2]) - (ELEM_W+1)'(rot[6]);
    assign dif_z = (ELEM_W+1)'(rot[3]) - (ELEM_W+1)'(rot[1]);

    assign neg_next.neg_x = dif_x[ELEM_W];
    assign neg_next.neg_y = dif_y[ELEM_W];
    assign neg_next.neg_z = dif_z[ELEM_W];

    // Entry stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_axis_tvalid;
        end
    end

    // Entry stage payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_reg[0] <= neg_next;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                rad_reg[0][l]  <= rad_next[l];
                rem_reg[0][l]  <= '0;
                root_reg[0][l] <= '0;
            end
        end
    end

    // Restoring square root, one result bit per stage in each lane.
    for (genvar s = 0; s < RB; s++)
    begin : g_stage

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                neg_reg[s+1] <= neg_reg[s];
            end
        end

        for (genvar l = 0; l < NUM_LANES; l++)
        begin : g_lane
            logic [CURW-1:0] cur;
            logic [CURW-1:0] trial;
            logic [CURW:0]   diff;
            logic            take;

            // Bring down the next two radicand bits and try to subtract 4r+1.
            assign cur   = {rem_reg[s][l], rad_reg[s][l][RADW-1 -: 2]};
            assign trial = CURW'({root_reg[s][l], 2'b01});
            assign diff  = {1'b0, cur} - {1'b0, trial};
            assign take  = !diff[CURW];

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rad_reg[s+1][l]  <= rad_reg[s][l] << 2;
                    rem_reg[s+1][l]  <= take ? diff[REMW-1:0] : cur[REMW-1:0];
                    root_reg[s+1][l] <= {root_reg[s][l][RB-2:0], take};
                end
            end
        end
    end

    // Halve, saturate and apply the signs.
    logic [QW_W-1:0]   mag [0:NUM_LANES-1];
    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_mag
        logic [EXTW-1:0] half;
        assign half   = EXTW'(root_reg[RB][l][RB-1:1]);
        assign mag[l] = (half > EXTW'(MAG_MAX)) ? MAG_MAX : half[QW_W-1:0];
    end

    logic [QXYZ_W-1:0] qx_next;
    logic [QXYZ_W-1:0] qy_next;
    logic [QXYZ_W-1:0] qz_next;

    assign qx_next = neg_reg[RB].neg_x ? -{1'b0, mag[LANE_X]} : {1'b0, mag[LANE_X]};
    assign qy_next = neg_reg[RB].neg_y ? -{1'b0, mag[LANE_Y]} : {1'b0, mag[LANE_Y]};
    assign qz_next = neg_reg[RB].neg_z ? -{1'b0, mag[LANE_Z]} : {1'b0, mag[LANE_Z]};

    // Output register.
    logic                  out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= vld_reg[RB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {1'b0, qz_next, qy_next, qx_next, mag[LANE_W]};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
